>>> sv/tlbfl_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package tlbfl_pkg;

    // Default geometry
    localparam int unsigned DEF_ENTRIES    = 16;
    localparam int unsigned DEF_PID_BITS   = 16;
    localparam int unsigned DEF_PAGE_BITS  = 20;
    localparam int unsigned DEF_FRAME_BITS = 20;

    // Fixed field widths
    localparam int unsigned SIZE_W      = 5;
    localparam int unsigned FRAME_OUT_W = 20;
    localparam int unsigned CFG_INDEX_W = 4;
    localparam int unsigned CFG_DATA_W  = 5;

    // Register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_TLB_SIZE       = 4'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_REPLACE_POLICY = 4'd1;

    // Reset values
    localparam logic [SIZE_W-1:0] TLB_SIZE_RESET = 5'd16;

    // Operation codes
    localparam logic OP_LOOKUP = 1'b0;
    localparam logic OP_FILL   = 1'b1;

    // Replacement policy codes
    localparam logic POLICY_FIFO = 1'b0;
    localparam logic POLICY_LRU  = 1'b1;

endpackage

`default_nettype wire

>>> sv/tlbfl_lru_pick.sv
`timescale 1ns / 1ps
`default_nettype none

module tlbfl_lru_pick #(
    parameter int unsigned ENTRIES = 16,
    parameter int unsigned RANK_W  = 4,
    parameter int unsigned CNT_W   = 5
) (
    input  wire logic              entry_valid [ENTRIES],
    input  wire logic [RANK_W-1:0] age_rank    [ENTRIES],
    input  wire logic [CNT_W-1:0]  eff_size,
    output logic [ENTRIES-1:0]     victim_sel
);

    logic [ENTRIES-1:0] in_window;

    // Mark entries that take part in replacement
    always_comb begin
        for (int i = 0; i < ENTRIES; i++) begin
            in_window[i] = entry_valid[i] && (CNT_W'(i) < eff_size);
        end
    end

    // Pairwise rank compare: the victim is older than every other candidate
    always_comb begin
        for (int i = 0; i < ENTRIES; i++) begin
            victim_sel[i] = in_window[i];
            for (int j = 0; j < ENTRIES; j++) begin
                if (j != i && in_window[j] && !(age_rank[j] < age_rank[i])) begin
                    victim_sel[i] = 1'b0;
                end
            end
        end
    end

endmodule

`default_nettype wire

>>> sv/tlb_fifo_lru_lookup_fill.sv
`timescale 1ns / 1ps
`default_nettype none

// Fully associative TLB, keyed by process id and page, holding a frame per entry.
// Input channel (s_*): op selects a lookup or a fill; a fill carries the frame
// fetched from memory after a miss and produces no result item.
// Result channel (m_*): one item per lookup with hit and frame_out (zero on miss).
// Config channel (cfg_*): index 0 sets tlb_size (0 disables, above the entry
// count saturates), index 1 sets the policy (0 FIFO, 1 LRU); always ready.
// A lookup passes two register stages (input register, result register). Throughput
// is one item per cycle while no held result stalls a lookup: the full tag compare,
// rank update and victim choice sit between the two registers, so each item sees
// the state the previous item left.
// The LRU victim is found by a pairwise rank compare across the valid entries below tlb_size.
// Reset: all entries invalid, ranks zero, fill count and FIFO pointer zero,
// size 16, FIFO policy; no clearing pass is needed.
// Stall: when m_ready is low and a result is held, a further lookup waits in the
// input register and s_ready drops; fills still go through.
module tlb_fifo_lru_lookup_fill
    #(
    parameter int unsigned ENTRIES    = tlbfl_pkg::DEF_ENTRIES,
    parameter int unsigned PID_BITS   = tlbfl_pkg::DEF_PID_BITS,
    parameter int unsigned PAGE_BITS  = tlbfl_pkg::DEF_PAGE_BITS,
    parameter int unsigned FRAME_BITS = tlbfl_pkg::DEF_FRAME_BITS
) (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,
    // Configuration
    input  wire logic                                  cfg_valid,
    output logic                                       cfg_ready,
    input  wire logic [tlbfl_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  wire logic [tlbfl_pkg::CFG_DATA_W-1:0]      cfg_data,
    // Input items
    input  wire logic                                  s_valid,
    output logic                                       s_ready,
    input  wire logic                                  s_op,
    input  wire logic [PID_BITS-1:0]                   s_pid,
    input  wire logic [PAGE_BITS-1:0]                  s_page,
    input  wire logic [FRAME_BITS-1:0]                 s_frame,
    // Result items
    output logic                                       m_valid,
    input  wire logic                                  m_ready,
    output logic                                       m_hit,
    output logic [tlbfl_pkg::FRAME_OUT_W-1:0]          m_frame_out
);

    import tlbfl_pkg::*;

    localparam int unsigned RANK_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int unsigned IDX_W  = RANK_W;
    localparam int unsigned CNT_W  = $clog2(ENTRIES + 1);

    // Configuration registers
    logic [SIZE_W-1:0] tlb_size_reg;
    logic              replace_policy_reg;

    // Input register
    logic                  in_vld_reg;
    logic                  in_op_reg;
    logic [PID_BITS-1:0]   in_pid_reg;
    logic [PAGE_BITS-1:0]  in_page_reg;
    logic [FRAME_BITS-1:0] in_frame_reg;

    // Entry storage
    logic                  entry_valid_reg [ENTRIES];
    logic [PID_BITS-1:0]   tag_pid_reg     [ENTRIES];
    logic [PAGE_BITS-1:0]  tag_page_reg    [ENTRIES];
    logic [FRAME_BITS-1:0] entry_frame_reg [ENTRIES];
    logic [RANK_W-1:0]     age_rank_reg    [ENTRIES];
    logic [CNT_W-1:0]      filled_reg;
    logic [IDX_W-1:0]      oldest_reg;

    // Result register
    logic                   out_vld_reg;
    logic                   out_hit_reg;
    logic [FRAME_OUT_W-1:0] out_frame_reg;

    // Processing signals
    logic [CNT_W-1:0]      eff_size;
    logic [ENTRIES-1:0]    match_sel;
    logic [ENTRIES-1:0]    free_sel;
    logic [ENTRIES-1:0]    fifo_sel;
    logic [ENTRIES-1:0]    lru_sel;
    logic [ENTRIES-1:0]    target_sel;
    logic [FRAME_BITS-1:0] hit_frame;
    logic [RANK_W-1:0]     target_rank;
    logic [IDX_W-1:0]      fifo_idx;
    logic [IDX_W-1:0]      oldest_next;
    logic                  key_hit;
    logic                  active;
    logic                  is_fill;
    logic                  tlb_full;
    logic                  lookup_hit;
    logic                  fill_upd;
    logic                  fill_new;
    logic                  fill_free;
    logic                  fill_fifo;
    logic                  fill_lru;
    logic                  proc;
    logic                  do_recent;
    logic                  do_age_all;

    // Handshake
    assign cfg_ready = 1'b1;
    assign proc      = in_vld_reg && (is_fill || !out_vld_reg || m_ready);
    assign s_ready   = !in_vld_reg || proc;
    assign m_valid   = out_vld_reg;
    assign m_hit     = out_hit_reg;
    assign m_frame_out = out_frame_reg;

    // Clamp the size to the entry count
    always_comb begin
        if (32'(tlb_size_reg) > 32'(ENTRIES)) begin
            eff_size = CNT_W'(ENTRIES);
        end else begin
            eff_size = CNT_W'(tlb_size_reg);
        end
    end

    // Parallel tag compare and frame select
    always_comb begin
        hit_frame = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            match_sel[i] = entry_valid_reg[i] && (tag_pid_reg[i] == in_pid_reg)
                           && (tag_page_reg[i] == in_page_reg);
            if (match_sel[i]) begin
                hit_frame = hit_frame | entry_frame_reg[i];
            end
        end
    end

    // Classify the item
    assign key_hit    = |match_sel;
    assign active     = (eff_size != '0);
    assign is_fill    = (in_op_reg == OP_FILL);
    assign tlb_full   = (filled_reg >= eff_size);
    assign lookup_hit = !is_fill && active && key_hit;
    assign fill_upd   = is_fill && active && key_hit;
    assign fill_new   = is_fill && active && !key_hit;
    assign fill_free  = fill_new && !tlb_full;
    assign fill_fifo  = fill_new && tlb_full && (replace_policy_reg == POLICY_FIFO);
    assign fill_lru   = fill_new && tlb_full && (replace_policy_reg == POLICY_LRU);
    assign do_recent  = proc && (lookup_hit || fill_upd || fill_fifo || fill_lru);
    assign do_age_all = proc && fill_free;

    // FIFO victim and pointer advance
    always_comb begin
        if (CNT_W'(oldest_reg) < eff_size) begin
            fifo_idx = oldest_reg;
        end else begin
            fifo_idx = '0;
        end
        if (CNT_W'(fifo_idx) + CNT_W'(1) == eff_size) begin
            oldest_next = '0;
        end else begin
            oldest_next = fifo_idx + IDX_W'(1);
        end
    end

    // Decode slot indexes to one-hot
    always_comb begin
        for (int i = 0; i < ENTRIES; i++) begin
            free_sel[i] = (filled_reg == CNT_W'(i));
            fifo_sel[i] = (fifo_idx == IDX_W'(i));
        end
    end

    tlbfl_lru_pick #(
        .ENTRIES (ENTRIES),
        .RANK_W  (RANK_W),
        .CNT_W   (CNT_W)
    ) u_lru_pick (
        .entry_valid (entry_valid_reg),
        .age_rank    (age_rank_reg),
        .eff_size    (eff_size),
        .victim_sel  (lru_sel)
    );

    // Choose the entry this item acts on, and its current rank
    always_comb begin
        if (lookup_hit || fill_upd) begin
            target_sel = match_sel;
        end else if (fill_free) begin
            target_sel = free_sel;
        end else if (fill_fifo) begin
            target_sel = fifo_sel;
        end else begin
            target_sel = lru_sel;
        end
        target_rank = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            if (target_sel[i]) begin
                target_rank = target_rank | age_rank_reg[i];
            end
        end
    end

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tlb_size_reg       <= TLB_SIZE_RESET;
            replace_policy_reg <= POLICY_FIFO;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                REG_TLB_SIZE:       tlb_size_reg       <= cfg_data[SIZE_W-1:0];
                REG_REPLACE_POLICY: replace_policy_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // Input register: load on accept, drop once processed
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (s_ready) begin
            in_vld_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_op_reg    <= s_op;
            in_pid_reg   <= s_pid;
            in_page_reg  <= s_page;
            in_frame_reg <= s_frame;
        end
    end

    // Valid bits and age ranks
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int j = 0; j < ENTRIES; j++) begin
                entry_valid_reg[j] <= 1'b0;
                age_rank_reg[j]    <= '0;
            end
        end else begin
            for (int j = 0; j < ENTRIES; j++) begin
                if (do_recent) begin
                    if (target_sel[j]) begin
                        age_rank_reg[j] <= '0;
                    end else if (entry_valid_reg[j] && (age_rank_reg[j] < target_rank)) begin
                        age_rank_reg[j] <= age_rank_reg[j] + RANK_W'(1);
                    end
                end else if (do_age_all) begin
                    if (target_sel[j]) begin
                        age_rank_reg[j]    <= '0;
                        entry_valid_reg[j] <= 1'b1;
                    end else if (entry_valid_reg[j]) begin
                        age_rank_reg[j] <= age_rank_reg[j] + RANK_W'(1);
                    end
                end
            end
        end
    end

    // Tags and frames
    always_ff @(posedge aclk) begin
        for (int j = 0; j < ENTRIES; j++) begin
            if (proc && (fill_upd || fill_new) && target_sel[j]) begin
                entry_frame_reg[j] <= in_frame_reg;
            end
            if (proc && fill_new && target_sel[j]) begin
                tag_pid_reg[j]  <= in_pid_reg;
                tag_page_reg[j] <= in_page_reg;
            end
        end
    end

    // Fill count and FIFO pointer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            filled_reg <= '0;
            oldest_reg <= '0;
        end else begin
            if (do_age_all) begin
                filled_reg <= filled_reg + CNT_W'(1);
            end
            if (proc && fill_fifo) begin
                oldest_reg <= oldest_next;
            end
        end
    end

    // Result register: load a lookup result, drop once taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (proc && !is_fill) begin
            out_vld_reg <= 1'b1;
        end else if (m_ready) begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (proc && !is_fill) begin
            out_hit_reg   <= lookup_hit;
            out_frame_reg <= lookup_hit ? FRAME_OUT_W'(hit_frame) : '0;
        end
    end

    // Checks
    logic [ENTRIES-1:0] valid_vec;

    always_comb begin
        for (int i = 0; i < ENTRIES; i++) begin
            valid_vec[i] = entry_valid_reg[i];
        end
    end

    a_keys_unique: assert property (@(posedge aclk) disable iff (!aresetn)
        in_vld_reg |-> $onehot0(match_sel))
        else $error("key held in more than one entry");

    a_fill_count: assert property (@(posedge aclk) disable iff (!aresetn)
        $countones(valid_vec) == 32'(filled_reg))
        else $error("fill count disagrees with valid bits");

    a_lru_victim: assert property (@(posedge aclk) disable iff (!aresetn)
        (proc && fill_lru) |-> $onehot(lru_sel))
        else $error("no unique LRU victim");

    a_lookup_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (proc && !is_fill) |=> out_vld_reg)
        else $error("lookup produced no result");

    a_fill_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        (proc && is_fill && !out_vld_reg) |=> !out_vld_reg)
        else $error("fill produced a result");

endmodule

`default_nettype wire

>>> verif/tb_tlb_fifo_lru_lookup_fill.sv
`timescale 1ns / 1ps

module tb_tlb_fifo_lru_lookup_fill;

    import tlbfl_pkg::*;

    localparam int ENTRIES = DEF_ENTRIES;
    localparam int PID_W   = DEF_PID_BITS;
    localparam int PAGE_W  = DEF_PAGE_BITS;
    localparam int FRAME_W = DEF_FRAME_BITS;

    // Two register stages from input to result, plus margin
    localparam int DRAIN_CYCLES = 4;
    localparam int LONG_HOLD    = 400;
    localparam int POOL_MAX     = 24;
    localparam int PHASES       = 14;
    localparam int unsigned TIMEOUT_NS = 8_000_000;

    // Index that decodes to no register
    localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 4'd9;

    typedef logic [PID_W-1:0]   pid_t;
    typedef logic [PAGE_W-1:0]  page_t;
    typedef logic [FRAME_W-1:0] frame_t;

    localparam pid_t   PID_MAX   = '1;
    localparam page_t  PAGE_MAX  = '1;
    localparam frame_t FRAME_MAX = '1;

    typedef struct packed {
        logic                   hit;
        logic [FRAME_OUT_W-1:0] frame;
    } xlate_t;

    typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

    // One directed step: an item, or a register write with its data in frame
    typedef struct {
        row_kind_t              kind;
        logic                   op;
        pid_t                   pid;
        page_t                  page;
        frame_t                 frame;
        logic [CFG_INDEX_W-1:0] idx;
        bit                     typed;
        logic                   t_hit;
        logic [FRAME_OUT_W-1:0] t_frame;
    } dir_row_t;

    typedef struct {
        logic [SIZE_W-1:0] size;
        logic              policy;
        int                items;
        int                pool;
        bit                steady;
        bit                long_hold;
        bit                extra_write;
    } phase_t;

    logic                   aclk;
    logic                   aresetn;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;
    logic                   s_valid;
    logic                   s_ready;
    logic                   s_op;
    pid_t                   s_pid;
    page_t                  s_page;
    frame_t                 s_frame;
    logic                   m_valid;
    logic                   m_ready;
    logic                   m_hit;
    logic [FRAME_OUT_W-1:0] m_frame_out;

    tlb_fifo_lru_lookup_fill dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_op        (s_op),
        .s_pid       (s_pid),
        .s_page      (s_page),
        .s_frame     (s_frame),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_hit       (m_hit),
        .m_frame_out (m_frame_out)
    );

    // Shadow TLB state
    logic              slot_valid   [ENTRIES];
    pid_t              cached_pid   [ENTRIES];
    page_t             cached_page  [ENTRIES];
    frame_t            cached_frame [ENTRIES];
    int                slot_rank    [ENTRIES];
    int                fill_cnt;
    int                fifo_ptr;
    logic [SIZE_W-1:0] cur_size;
    logic              cur_policy;

    xlate_t lookup_q [$];
    xlate_t got_exp;
    int     fail_cnt;
    int     n_lookups, n_hits, n_fills, n_evict, n_cfg;
    bit     last_hit;
    bit     no_idle;
    bit     long_hold_req;

    pid_t   pool_pid  [POOL_MAX];
    page_t  pool_page [POOL_MAX];

    dir_row_t dir_tab [$];

    phase_t plan [PHASES] = '{
        '{5'd16, POLICY_FIFO, 160, 20, 1'b1, 1'b1, 1'b0},
        '{5'd16, POLICY_LRU,  160, 20, 1'b0, 1'b0, 1'b0},
        '{5'd1,  POLICY_FIFO,  80,  3, 1'b0, 1'b0, 1'b0},
        '{5'd1,  POLICY_LRU,   80,  3, 1'b0, 1'b0, 1'b0},
        '{5'd2,  POLICY_LRU,  100,  4, 1'b1, 1'b0, 1'b0},
        '{5'd0,  POLICY_FIFO,  30,  6, 1'b0, 1'b0, 1'b1},
        '{5'd31, POLICY_LRU,  160, 22, 1'b0, 1'b0, 1'b0},
        '{5'd4,  POLICY_FIFO, 120,  7, 1'b0, 1'b0, 1'b0},
        '{5'd3,  POLICY_LRU,  120,  8, 1'b0, 1'b0, 1'b0},
        '{5'd3,  POLICY_FIFO, 100,  8, 1'b0, 1'b0, 1'b0},
        '{5'd8,  POLICY_FIFO, 140, 12, 1'b1, 1'b0, 1'b0},
        '{5'd16, POLICY_LRU,  160, 24, 1'b0, 1'b0, 1'b0},
        '{5'd5,  POLICY_LRU,  100,  9, 1'b0, 1'b0, 1'b0},
        '{5'd12, POLICY_FIFO, 130, 16, 1'b0, 1'b0, 1'b0}
    };

    // Clock
    always begin
        aclk = 1'b0;
        #4;
        aclk = 1'b1;
        #4;
    end

    function automatic int eff_size();
        return (cur_size > ENTRIES) ? ENTRIES : int'(cur_size);
    endfunction

    // Move one slot to rank zero, aging those that were more recent
    function automatic void make_newest(input int s);
        int r;
        r = slot_rank[s];
        for (int j = 0; j < ENTRIES; j++)
            if (slot_valid[j] && slot_rank[j] < r)
                slot_rank[j]++;
        slot_rank[s] = 0;
    endfunction

    // Apply one item to the shadow TLB; returns 1 when it yields a result
    function automatic bit tlb_translate(input logic op, input pid_t pid, input page_t page,
                                         input frame_t frame, output xlate_t res);
        int  slot;
        int  eff;
        int  best;
        bit  found;
        eff   = eff_size();
        found = 1'b0;
        slot  = 0;
        res   = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            if (!found && slot_valid[i] && cached_pid[i] == pid && cached_page[i] == page) begin
                slot  = i;
                found = 1'b1;
            end
        end

        if (op == OP_LOOKUP) begin
            n_lookups++;
            if (eff != 0 && found) begin
                make_newest(slot);
                res.hit   = 1'b1;
                res.frame = cached_frame[slot];
                n_hits++;
            end
            return 1'b1;
        end

        // Disabled buffer drops fills
        if (eff == 0)
            return 1'b0;
        n_fills++;

        // Refill of a held key stays in place
        if (found) begin
            cached_frame[slot] = frame;
            make_newest(slot);
            return 1'b0;
        end

        if (fill_cnt < eff) begin
            slot = fill_cnt;
            for (int i = 0; i < ENTRIES; i++)
                if (slot_valid[i])
                    slot_rank[i]++;
            slot_valid[slot] = 1'b1;
            slot_rank[slot]  = 0;
            fill_cnt++;
        end else if (cur_policy == POLICY_FIFO) begin
            slot     = (fifo_ptr < eff) ? fifo_ptr : 0;
            fifo_ptr = (slot + 1 == eff) ? 0 : slot + 1;
            make_newest(slot);
            n_evict++;
        end else begin
            // Oldest rank among the slots in use, last one on a tie
            best = 0;
            slot = 0;
            for (int i = 0; i < eff; i++) begin
                if (slot_valid[i] && slot_rank[i] >= best) begin
                    best = slot_rank[i];
                    slot = i;
                end
            end
            make_newest(slot);
            n_evict++;
        end
        cached_pid[slot]   = pid;
        cached_page[slot]  = page;
        cached_frame[slot] = frame;
        return 1'b0;
    endfunction

    // Mostly short gaps, now and then a long one
    function automatic int pick_gap();
        return ($urandom_range(0, 19) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 3);
    endfunction

    // Offer one item, hold it until accepted, then predict its result
    task automatic send_item(input logic op, input pid_t pid, input page_t page,
                             input frame_t frame, input bit typed, input logic t_hit,
                             input logic [FRAME_OUT_W-1:0] t_frame);
        xlate_t res;
        s_valid <= 1'b1;
        s_op    <= op;
        s_pid   <= pid;
        s_page  <= page;
        s_frame <= frame;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        if (tlb_translate(op, pid, page, frame, res)) begin
            if (typed) begin
                res.hit   = t_hit;
                res.frame = t_frame;
            end
            lookup_q.push_back(res);
        end
        last_hit = res.hit;
    endtask

    task automatic sender_gap();
        if (!no_idle && $urandom_range(0, 2) == 0) begin
            s_valid <= 1'b0;
            repeat (pick_gap())
                @(posedge aclk);
        end
    endtask

    // Drop valid and let every pending result come out
    task automatic wait_drained();
        s_valid <= 1'b0;
        while (lookup_q.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES)
            @(posedge aclk);
    endtask

    task automatic write_cfg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge aclk);
        while (!cfg_ready)
            @(posedge aclk);
        if (idx == REG_TLB_SIZE)
            cur_size = data;
        else if (idx == REG_REPLACE_POLICY)
            cur_policy = data[0];
        n_cfg++;
    endtask

    // Compare each accepted result with the oldest prediction
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (lookup_q.size() == 0) begin
                $error("result with no lookup pending: hit=%0d frame_out=%h", m_hit, m_frame_out);
                fail_cnt++;
            end else begin
                got_exp = lookup_q.pop_front();
                if (m_hit !== got_exp.hit) begin
                    $error("hit: expected %0d, actual %0d", got_exp.hit, m_hit);
                    fail_cnt++;
                end
                if (m_frame_out !== got_exp.frame) begin
                    $error("frame_out: expected %h, actual %h", got_exp.frame, m_frame_out);
                    fail_cnt++;
                end
            end
        end
    end

    // Result side back-pressure
    initial begin
        m_ready <= 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                m_ready <= 1'b0;
                repeat (LONG_HOLD)
                    @(posedge aclk);
            end else if (!no_idle && $urandom_range(0, 1) == 0) begin
                m_ready <= 1'b0;
                repeat (pick_gap())
                    @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
        end
    end

    // Run limit
    initial begin
        #(TIMEOUT_NS);
        $display("FAIL tlb_fifo_lru_lookup_fill");
        $finish;
    end

    // Stimulus
    initial begin
        int     items_done;
        int     k;
        int     sel;
        int     r;
        frame_t fr;

        aresetn   <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        s_valid   <= 1'b0;
        s_op      <= OP_LOOKUP;
        s_pid     <= '0;
        s_page    <= '0;
        s_frame   <= '0;

        for (int i = 0; i < ENTRIES; i++) begin
            slot_valid[i]   = 1'b0;
            slot_rank[i]    = 0;
            cached_pid[i]   = '0;
            cached_page[i]  = '0;
            cached_frame[i] = '0;
        end
        fill_cnt      = 0;
        fifo_ptr      = 0;
        cur_size      = TLB_SIZE_RESET;
        cur_policy    = POLICY_FIFO;
        fail_cnt      = 0;
        n_lookups     = 0;
        n_hits        = 0;
        n_fills       = 0;
        n_evict       = 0;
        n_cfg         = 0;
        last_hit      = 1'b0;
        no_idle       = 1'b0;
        long_hold_req = 1'b0;
        for (int i = 0; i < POOL_MAX; i++) begin
            pool_pid[i]  = pid_t'($urandom);
            pool_page[i] = page_t'($urandom);
        end

        // Directed: extremes, overwrite in place, disabled buffer, size below held count
        dir_tab = '{
            '{ROW_ITEM, OP_LOOKUP, PID_MAX, PAGE_MAX, '0, REG_TLB_SIZE, 1'b1, 1'b0, '0},
            '{ROW_ITEM, OP_LOOKUP, '0, '0, FRAME_MAX, REG_TLB_SIZE, 1'b1, 1'b0, '0},
            '{ROW_ITEM, OP_FILL, PID_MAX, PAGE_MAX, FRAME_MAX, REG_TLB_SIZE, 1'b0, 1'b0, '0},
            '{ROW_ITEM, OP_LOOKUP, PID_MAX, PAGE_MAX, '0, REG_TLB_SIZE, 1'b1, 1'b1, 20'hFFFFF},
            '{ROW_ITEM, OP_FILL, '0, '0, '0, REG_TLB_SIZE, 1'b0, 1'b0, '0},
            '{ROW_ITEM, OP_LOOKUP, '0, '0, FRAME_MAX, REG_TLB_SIZE, 1'b1, 1'b1, '0},
            '{ROW_ITEM, OP_LOOKUP, PID_MAX, '0, '0, REG_TLB_SIZE, 1'b1, 1'b0, '0},
            '{ROW_ITEM, OP_LOOKUP, '0, PAGE_MAX, '0, REG_TLB_SIZE, 1'b1, 1'b0, '0},
            '{ROW_ITEM, OP_FILL, '0, '0, 20'hAAAAA, REG_TLB_SIZE, 1'b0, 1'b0, '0},
            '{ROW_ITEM, OP_LOOKUP, '0, '0, '0, REG_TLB_SIZE, 1'b1, 1'b1, 20'hAAAAA},
            '{ROW_ITEM, OP_FILL, 16'h5555, 20'h55555, 20'h55555, REG_TLB_SIZE, 1'b0, 1'b0, '0},
            '{ROW_ITEM, OP_LOOKUP, 16'h5555, 20'h55555, '0, REG_TLB_SIZE, 1'b1, 1'b1, 20'h55555},
            '{ROW_ITEM, OP_FILL, 16'hAAAA, 20'hAAAAA, 20'h12345, REG_TLB_SIZE, 1'b0, 1'b0, '0},
            '{ROW_ITEM, OP_LOOKUP, 16'hAAAA, 20'hAAAAA, '0, REG_TLB_SIZE, 1'b0, 1'b0, '0},
            '{ROW_ITEM, OP_LOOKUP, 16'h1234, 20'h56789, '0, REG_TLB_SIZE, 1'b1, 1'b0, '0},
            '{ROW_ITEM, OP_FILL, 16'h1234, 20'h56789, 20'h0F0F0, REG_TLB_SIZE, 1'b0, 1'b0, '0},
            '{ROW_ITEM, OP_LOOKUP, 16'h1234, 20'h56789, '0, REG_TLB_SIZE, 1'b0, 1'b0, '0},
            '{ROW_ITEM, OP_FILL, PID_MAX, PAGE_MAX, 20'h00001, REG_TLB_SIZE, 1'b0, 1'b0, '0},
            '{ROW_ITEM, OP_LOOKUP, PID_MAX, PAGE_MAX, '0, REG_TLB_SIZE, 1'b0, 1'b0, '0},
            '{ROW_CFG, OP_LOOKUP, '0, '0, 20'd0, REG_TLB_SIZE, 1'b0, 1'b0, '0},
            '{ROW_ITEM, OP_LOOKUP, PID_MAX, PAGE_MAX, '0, REG_TLB_SIZE, 1'b1, 1'b0, '0},
            '{ROW_ITEM, OP_FILL, 16'h1111, 20'h11111, 20'h11111, REG_TLB_SIZE, 1'b0, 1'b0, '0},
            '{ROW_ITEM, OP_LOOKUP, 16'h1111, 20'h11111, '0, REG_TLB_SIZE, 1'b1, 1'b0, '0},
            '{ROW_CFG, OP_LOOKUP, '0, '0, 20'd16, REG_TLB_SIZE, 1'b0, 1'b0, '0},
            '{ROW_ITEM, OP_LOOKUP, PID_MAX, PAGE_MAX, '0, REG_TLB_SIZE, 1'b0, 1'b0, '0},
            '{ROW_CFG, OP_LOOKUP, '0, '0, 20'd2, REG_TLB_SIZE, 1'b0, 1'b0, '0},
            '{ROW_CFG, OP_LOOKUP, '0, '0, 20'd1, REG_REPLACE_POLICY, 1'b0, 1'b0, '0},
            '{ROW_ITEM, OP_FILL, 16'h2222, 20'h22222, 20'h22222, REG_TLB_SIZE, 1'b0, 1'b0, '0},
            '{ROW_ITEM, OP_LOOKUP, 16'h5555, 20'h55555, '0, REG_TLB_SIZE, 1'b0, 1'b0, '0}
        };

        // Hold reset, then release
        repeat (6)
            @(posedge aclk);
        aresetn <= 1'b1;

        // Walk the directed table
        foreach (dir_tab[i]) begin
            if (dir_tab[i].kind == ROW_CFG) begin
                wait_drained();
                write_cfg(dir_tab[i].idx, dir_tab[i].frame[CFG_DATA_W-1:0]);
                cfg_valid <= 1'b0;
            end else begin
                sender_gap();
                send_item(dir_tab[i].op, dir_tab[i].pid, dir_tab[i].page, dir_tab[i].frame,
                          dir_tab[i].typed, dir_tab[i].t_hit, dir_tab[i].t_frame);
            end
        end

        // Random phases, each under its own setting
        for (int p = 0; p < PHASES; p++) begin
            wait_drained();
            write_cfg(REG_TLB_SIZE, plan[p].size);
            write_cfg(REG_REPLACE_POLICY, {4'($urandom), plan[p].policy});
            if (plan[p].extra_write)
                write_cfg(REG_UNUSED, 5'($urandom));
            cfg_valid <= 1'b0;

            // Keep about half of the keys so held entries get hit again
            for (int i = 0; i < POOL_MAX; i++) begin
                if ($urandom_range(0, 1) == 0) begin
                    r = $urandom_range(0, 7);
                    pool_pid[i]  = (r == 0) ? '0 : (r == 1) ? PID_MAX : pid_t'($urandom);
                    r = $urandom_range(0, 7);
                    pool_page[i] = (r == 0) ? '0 : (r == 1) ? PAGE_MAX : page_t'($urandom);
                end
            end

            no_idle = plan[p].steady;
            if (plan[p].long_hold)
                long_hold_req = 1'b1;

            items_done = 0;
            while (items_done < plan[p].items) begin
                sel = $urandom_range(0, 99);
                k   = $urandom_range(0, plan[p].pool - 1);
                fr  = frame_t'($urandom);
                if (sel < 60) begin
                    // Lookup, and on a miss usually the fill that follows it
                    sender_gap();
                    send_item(OP_LOOKUP, pool_pid[k], pool_page[k], fr, 1'b0, 1'b0, '0);
                    items_done++;
                    if (!last_hit && eff_size() != 0 && $urandom_range(0, 9) != 0) begin
                        sender_gap();
                        send_item(OP_FILL, pool_pid[k], pool_page[k], frame_t'($urandom),
                                  1'b0, 1'b0, '0);
                        items_done++;
                    end
                end else if (sel < 75) begin
                    sender_gap();
                    if (eff_size() != 0)
                        items_done++;
                    send_item(OP_FILL, pool_pid[k], pool_page[k], fr, 1'b0, 1'b0, '0);
                end else if (sel < 90) begin
                    sender_gap();
                    send_item(OP_LOOKUP, pid_t'($urandom), page_t'($urandom), fr,
                              1'b0, 1'b0, '0);
                    items_done++;
                end else begin
                    sender_gap();
                    if (eff_size() != 0)
                        items_done++;
                    send_item(OP_FILL, pid_t'($urandom), page_t'($urandom), fr,
                              1'b0, 1'b0, '0);
                end
            end
        end

        wait_drained();
        $display("Covered %0d lookups with %0d hits, %0d fills with %0d replacements,",
                 n_lookups, n_hits, n_fills, n_evict);
        $display("under %0d register writes spanning sizes 0 to 31 and both policies.", n_cfg);
        if (fail_cnt == 0 && lookup_q.size() == 0) begin
            $display("PASS tlb_fifo_lru_lookup_fill");
        end else begin
            $display("FAIL tlb_fifo_lru_lookup_fill");
        end
        $finish;
    end

endmodule

>>> filelist.f
sv/tlbfl_pkg.sv
sv/tlbfl_lru_pick.sv
sv/tlb_fifo_lru_lookup_fill.sv
verif/tb_tlb_fifo_lru_lookup_fill.sv
